>>> rtl/core/timer_deadline_table_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timer deadline table
// Implication checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TIMER_DEADLINE_TABLE_TOP_ASSERT_SVH
`define TIMER_DEADLINE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define TDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TDT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/tdt_pkg.sv
// ----------------------------------------------------------------------------
// tdt_pkg
// Sizes, codes and helpers shared by the timer deadline table.
// ----------------------------------------------------------------------------
package tdt_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int TIME_BITS  = 48;
  localparam int IV_W       = 32;
  localparam int ENTRY_W    = TIME_BITS + IV_W;

  // Stream payload layout.
  localparam int IN_DL_LSB   = SLOT_W;
  localparam int IN_IV_LSB   = IN_DL_LSB + TIME_BITS;
  localparam int IN_NOW_LSB  = IN_IV_LSB + IV_W;
  localparam int IN_USED_W   = IN_NOW_LSB + TIME_BITS;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_FND_BIT = SLOT_W;
  localparam int OUT_CHG_BIT = SLOT_W + 1;
  localparam int OUT_NXT_LSB = SLOT_W + 2;
  localparam int OUT_DV_BIT  = OUT_NXT_LSB + TIME_BITS;
  localparam int OUT_USED_W  = OUT_DV_BIT + 1;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [IV_W-1:0]      ival_t;
  typedef logic [SLOT_W-1:0]    slot_t;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_IGNORE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_EXPIRED = 2'd0,
    KIND_ADD     = 2'd1,
    KIND_CANCEL  = 2'd2,
    KIND_TICK    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIN,
    ST_DUE,
    ST_PICK,
    ST_EXPIRE,
    ST_REARM,
    ST_DONE
  } state_e;

  // Rearm time, saturating at the largest representable time.
  function automatic time_t sat_add(time_t base, ival_t step);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, base} + {{(TIME_BITS + 1 - IV_W){1'b0}}, step};
    return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  endfunction

endpackage

>>> rtl/core/timer_deadline_table_top.sv
// ----------------------------------------------------------------------------
// timer_deadline_table_top
// Table of timer slots with add, cancel and tick, expiries in deadline order.
// ----------------------------------------------------------------------------
// Usage: one command item enters on the slave stream (tuser carries the
// operation), and every result item leaves on the master stream, tuser giving
// its kind and tlast marking the final result of the command.
// Deadlines and intervals live in one synchronous RAM read one entry a cycle;
// active marks sit in flip-flops. An add, cancel or unused code takes one
// min pass. A tick with k expired slots takes a due pass, k + 1 selection
// passes, each but the last followed by an expiry, and a rearm pass that
// also finds the next deadline.
// One command is worked on at a time; the next is taken once the final
// result has been placed in the output register, even while that waits.
// Reset clears every active mark; the RAM is not cleared, since an inactive
// entry is never used. A stalled receiver holds the output register and the
// table waits until it drains.
// ----------------------------------------------------------------------------
`include "timer_deadline_table_top_assert.svh"

module timer_deadline_table_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata, lowest bit up: slot, deadline, interval, now, zero pad
  input  logic [tdt_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // tuser: operation
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata, lowest bit up: slot_out, found, earliest_changed, next_deadline,
  // deadline_valid, zero pad
  output logic [tdt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // tuser: kind
  output logic [1:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  import tdt_pkg::*;

  // Table memory: {interval, deadline} per slot.
  logic [ENTRY_W-1:0] mem [NUM_SLOTS];
  logic [ENTRY_W-1:0] rdata_q;
  logic               rd_en;
  slot_t              rd_addr;
  logic               wr_en;
  slot_t              wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               rv_q, rv_d;
  slot_t              ridx_q, ridx_d;

  logic [NUM_SLOTS-1:0] active_q, active_d;
  logic [NUM_SLOTS-1:0] due_q, due_d;
  logic [NUM_SLOTS-1:0] pend_q, pend_d;
  time_t              best_q, best_d;
  logic               any_q, any_d;
  slot_t              pick_q, pick_d;

  op_e                op_q;
  slot_t              slot_q;
  time_t              dl_q;
  ival_t              iv_q;
  time_t              now_q;
  logic               hit_q;
  logic               add_ok_q;

  logic               out_valid_q, out_valid_d;
  kind_e              out_kind_q, out_kind_d;
  slot_t              out_slot_q, out_slot_d;
  logic               out_fnd_q, out_fnd_d;
  logic               out_chg_q, out_chg_d;
  time_t              out_next_q, out_next_d;
  logic               out_dv_q, out_dv_d;
  logic               out_last_q, out_last_d;

  logic               s_fire;
  slot_t              in_slot;
  op_e                in_op;
  logic               in_range;
  logic               scan_st;
  logic               scan_last;
  logic               out_free;
  logic               out_ld;
  time_t              e_dl;
  ival_t              e_iv;
  time_t              rearm_dl;
  logic               cand;
  time_t              cand_dl;
  logic               take;
  logic               add_earlier;
  time_t              cur_next;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_slot         = s_axis_tdata_i[SLOT_W-1:0];
  assign in_op           = op_e'(s_axis_tuser_i);
  assign in_range        = (32'(in_slot) < NUM_SLOTS);

  assign scan_st   = (state_q == ST_MIN) || (state_q == ST_DUE) ||
                     (state_q == ST_PICK) || (state_q == ST_REARM);
  assign rd_en     = scan_st && (cnt_q < CNT_W'(NUM_SLOTS));
  assign rd_addr   = cnt_q[SLOT_W-1:0];
  assign scan_last = rv_q && (ridx_q == SLOT_W'(NUM_SLOTS - 1));
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign out_ld    = out_free && ((state_q == ST_EXPIRE) || (state_q == ST_DONE));

  assign e_dl     = rdata_q[TIME_BITS-1:0];
  assign e_iv     = rdata_q[ENTRY_W-1:TIME_BITS];
  assign rearm_dl = sat_add(now_q, e_iv);

  // Candidate offered by the entry that has just been read.
  always_comb begin
    cand    = 1'b0;
    cand_dl = e_dl;
    unique case (state_q)
      ST_MIN:   cand = active_q[ridx_q] && !(add_ok_q && (ridx_q == slot_q));
      ST_PICK:  cand = pend_q[ridx_q];
      ST_REARM: begin
        cand    = active_q[ridx_q] && !(due_q[ridx_q] && (e_iv == '0));
        cand_dl = due_q[ridx_q] ? rearm_dl : e_dl;
      end
      default: cand = 1'b0;
    endcase
  end

  // Strict compare with ascending index keeps ties on the lower slot.
  assign take = rv_q && cand && (!any_q || (cand_dl < best_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_fire) begin
        state_d = (in_op == OP_TICK) ? ST_DUE : ST_MIN;
      end
      ST_MIN:    if (scan_last) state_d = ST_DONE;
      ST_DUE:    if (scan_last) state_d = ST_PICK;
      ST_PICK:   if (scan_last) state_d = (any_q || take) ? ST_EXPIRE : ST_REARM;
      ST_EXPIRE: if (out_free) state_d = ST_PICK;
      ST_REARM:  if (scan_last) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign add_earlier = !any_q || (dl_q < best_q);
  assign cur_next    = any_q ? best_q : '0;

  always_comb begin
    cnt_d    = rd_en ? cnt_q + CNT_W'(1) : cnt_q;
    rv_d     = rd_en;
    ridx_d   = rd_addr;
    active_d = active_q;
    due_d    = due_q;
    pend_d   = pend_q;
    best_d   = best_q;
    any_d    = any_q;
    pick_d   = pick_q;
    wr_en    = 1'b0;
    wr_addr  = ridx_q;
    wr_data  = {e_iv, rearm_dl};

    if (take) begin
      best_d = cand_dl;
      any_d  = 1'b1;
      pick_d = ridx_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && (in_op == OP_CANCEL) && in_range) active_d[in_slot] = 1'b0;
      end
      ST_DUE: begin
        if (rv_q) begin
          due_d[ridx_q]  = active_q[ridx_q] && (e_dl < now_q);
          pend_d[ridx_q] = active_q[ridx_q] && (e_dl < now_q);
        end
      end
      ST_EXPIRE: begin
        if (out_free) pend_d[pick_q] = 1'b0;
      end
      ST_REARM: begin
        if (rv_q && due_q[ridx_q]) begin
          if (e_iv != '0) wr_en = 1'b1;
          else active_d[ridx_q] = 1'b0;
        end
      end
      ST_DONE: begin
        if (out_free && add_ok_q) begin
          wr_en            = 1'b1;
          wr_addr          = slot_q;
          wr_data          = {iv_q, dl_q};
          active_d[slot_q] = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Each pass starts from the first entry with an empty running minimum.
    if ((state_d != state_q) && ((state_d == ST_MIN) || (state_d == ST_DUE) ||
        (state_d == ST_PICK) || (state_d == ST_REARM))) begin
      cnt_d = '0;
      any_d = 1'b0;
      best_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_kind_d  = out_kind_q;
    out_slot_d  = out_slot_q;
    out_fnd_d   = out_fnd_q;
    out_chg_d   = out_chg_q;
    out_next_d  = out_next_q;
    out_dv_d    = out_dv_q;
    out_last_d  = out_last_q;
    if (out_ld) begin
      out_valid_d = 1'b1;
      out_fnd_d   = 1'b0;
      out_chg_d   = 1'b0;
      out_next_d  = cur_next;
      out_dv_d    = any_q;
      out_last_d  = 1'b1;
      out_slot_d  = slot_q;
      if (state_q == ST_EXPIRE) begin
        out_kind_d = KIND_EXPIRED;
        out_slot_d = pick_q;
        out_next_d = '0;
        out_dv_d   = 1'b0;
        out_last_d = 1'b0;
      end else begin
        unique case (op_q)
          OP_ADD: begin
            out_kind_d = KIND_ADD;
            if (add_ok_q) begin
              out_chg_d  = add_earlier;
              out_next_d = add_earlier ? dl_q : best_q;
              out_dv_d   = 1'b1;
            end
          end
          OP_CANCEL: begin
            out_kind_d = KIND_CANCEL;
            out_fnd_d  = hit_q;
          end
          OP_TICK, OP_IGNORE: begin
            out_kind_d = KIND_TICK;
            out_slot_d = '0;
          end
          default: out_kind_d = KIND_TICK;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      active_q    <= '0;
      due_q       <= '0;
      pend_q      <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rv_q        <= rv_d;
      active_q    <= active_d;
      due_q       <= due_d;
      pend_q      <= pend_d;
      any_q       <= any_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q     <= ridx_d;
    best_q     <= best_d;
    pick_q     <= pick_d;
    out_kind_q <= out_kind_d;
    out_slot_q <= out_slot_d;
    out_fnd_q  <= out_fnd_d;
    out_chg_q  <= out_chg_d;
    out_next_q <= out_next_d;
    out_dv_q   <= out_dv_d;
    out_last_q <= out_last_d;
    if (s_fire) begin
      op_q     <= in_op;
      slot_q   <= in_slot;
      dl_q     <= s_axis_tdata_i[IN_DL_LSB +: TIME_BITS];
      iv_q     <= s_axis_tdata_i[IN_IV_LSB +: IV_W];
      now_q    <= s_axis_tdata_i[IN_NOW_LSB +: TIME_BITS];
      hit_q    <= (in_op == OP_CANCEL) && in_range && active_q[in_slot];
      add_ok_q <= (in_op == OP_ADD) && in_range;
    end
  end

  // Reads and writes within one pass always target different entries, and a
  // slot written at the end of an add is read only by a later command.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_dv_q, out_next_q,
                            out_chg_q, out_fnd_q, out_slot_q};

  `TDT_ASSERT_IMP(a_pend_due, 1'b1, (pend_q & ~due_q) == '0,
                  "pending expiry on a slot that was not due")
  `TDT_ASSERT_IMP(a_expire_pick, state_q == ST_EXPIRE, pend_q[pick_q] && due_q[pick_q],
                  "expiry emitted for a slot that is not pending")
  `TDT_ASSERT_NXT(a_accept_busy, s_fire, state_q != ST_IDLE,
                  "command accepted but table did not start work")
  `TDT_ASSERT_IMP(a_empty_zero, out_valid_q && !out_dv_q, out_next_q == '0,
                  "empty table reported a non-zero next deadline")

endmodule
